// ===== rtl/core/dfr_pkg.sv =====
// Shared types, constants and control structs for the display frame receiver.
`default_nettype none

package dfr_pkg;

  localparam int unsigned PAYLOAD_DEPTH = 64;
  localparam int unsigned PAY_AW        = $clog2(PAYLOAD_DEPTH);
  localparam int unsigned MAX_ELEMENTS  = 63;

  localparam logic [7:0] HDR_FIRST_RST = 8'h5A;
  localparam logic [7:0] HDR_SECOND_RST = 8'hA5;
  localparam logic [7:0] CMD_RW_RST    = 8'h80;
  localparam logic [7:0] CMD_RR_RST    = 8'h81;
  localparam logic [7:0] CMD_VW_RST    = 8'h82;
  localparam logic [7:0] CMD_VR_RST    = 8'h83;

  localparam logic [7:0] ACK_LENGTH = 8'h03;
  localparam logic [7:0] ACK_CHAR_O = 8'h4F;
  localparam logic [7:0] ACK_CHAR_K = 8'h4B;

  typedef enum logic [2:0] {
    CFG_HDR_FIRST  = 3'd0,
    CFG_HDR_SECOND = 3'd1,
    CFG_CMD_RW     = 3'd2,
    CFG_CMD_RR     = 3'd3,
    CFG_CMD_VW     = 3'd4,
    CFG_CMD_VR     = 3'd5
  } cfg_idx_t;

  typedef enum logic [2:0] {
    KIND_ACK      = 3'd0,
    KIND_VAR      = 3'd1,
    KIND_REG      = 3'd2,
    KIND_OTHER    = 3'd3,
    KIND_HDR_ERR  = 3'd4,
    KIND_OVERFLOW = 3'd5
  } kind_t;

  typedef enum logic [3:0] {
    S_H1, S_H2, S_LEN, S_CMD, S_PAY,
    S_A0, S_A1, S_A2, S_A3, S_CLS,
    S_HEAD, S_RH, S_RL, S_CL, S_OUT
  } state_t;

  typedef enum logic [1:0] {
    EM_NONE, EM_HDR, EM_HEAD, EM_ELEM
  } emit_t;

  typedef enum logic [2:0] {
    RS_B0, RS_B1, RS_B2, RS_HI, RS_LO
  } rsel_t;

  typedef struct packed {
    logic  cap_len;
    logic  cap_cmd;
    logic  pay_wr;
    rsel_t rsel;
    logic  cap_b0;
    logic  cap_b1;
    logic  cap_b2;
    logic  classify;
    logic  cap_hi;
    logic  cap_lo;
    logic  elem_inc;
    emit_t emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic hdr1_ok;
    logic hdr2_ok;
    logic pay_done;
    logic slot_free;
    logic head_last;
    logic elem_last;
    logic is_var;
  } ctrl_sts_t;

endpackage

`default_nettype wire

// ===== rtl/core/dfr_datapath.sv =====
// Datapath: config registers, payload memory, decode registers and output register.
`default_nettype none

module dfr_datapath (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic [7:0]         in_tdata,
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [7:0]         cfg_wdata,
  input  wire dfr_pkg::ctrl_cmd_t cmd_i,
  output dfr_pkg::ctrl_sts_t      sts_o,
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  output logic [47:0]             out_tdata,
  output logic [2:0]              out_tuser,
  output logic                    out_tlast
);

  localparam logic [8:0] DEPTH9 = 9'(dfr_pkg::PAYLOAD_DEPTH);
  localparam logic [8:0] MAXE9  = 9'(dfr_pkg::MAX_ELEMENTS);

  logic [7:0] hdr1_r, hdr2_r, cmd_rw_r, cmd_rr_r, cmd_vw_r, cmd_vr_r;
  logic [7:0] len_r, cmdb_r;
  logic [7:0] cnt_r;
  logic       ovf_r;
  logic [7:0] mem [dfr_pkg::PAYLOAD_DEPTH];
  logic [7:0] rd_data_r;
  logic       rd_ok_r;
  logic [7:0] b0_r, b1_r, b2_r, hi_r, lo_r;
  dfr_pkg::kind_t kind_r, kind_nxt;
  logic [15:0] addr_r, addr_nxt;
  logic [5:0] total_r, total_nxt;
  logic [5:0] elem_r;

  logic        out_valid_r;
  logic [2:0]  o_kind_r;
  logic [7:0]  o_cmd_r;
  logic [15:0] o_addr_r;
  logic        o_hv_r;
  logic [15:0] o_val_r;
  logic [5:0]  o_idx_r;
  logic        o_last_r;

  logic [8:0] cnt9, n9, need9, avail3, avail2, lim_v, lim_g, vtot, rtot;
  logic [7:0] need, rd_idx, byte_in;
  logic       slot_free, ack_hit, head_last, elem_last;

  always_comb begin
    cnt9      = {1'b0, cnt_r};
    n9        = (cnt9 >= DEPTH9) ? DEPTH9 : cnt9;
    need      = (len_r == 8'd0) ? 8'd0 : len_r - 8'd1;
    need9     = {1'b0, need};
    slot_free = !out_valid_r || out_tready;
    byte_in   = rd_ok_r ? rd_data_r : 8'd0;
    head_last = (total_r == 6'd0);
    elem_last = ({1'b0, elem_r} + 7'd1) == {1'b0, total_r};
  end

  always_comb begin
    case (cmd_i.rsel)
      dfr_pkg::RS_B0: rd_idx = 8'd0;
      dfr_pkg::RS_B1: rd_idx = 8'd1;
      dfr_pkg::RS_B2: rd_idx = 8'd2;
      dfr_pkg::RS_HI: rd_idx = (kind_r == dfr_pkg::KIND_VAR) ?
                               8'd3 + {1'b0, elem_r, 1'b0} : 8'd2 + {2'b0, elem_r};
      dfr_pkg::RS_LO: rd_idx = 8'd4 + {1'b0, elem_r, 1'b0};
      default:        rd_idx = 8'd0;
    endcase
  end

  always_comb begin
    avail3  = (n9 > 9'd3) ? n9 - 9'd3 : 9'd0;
    avail2  = (n9 > 9'd2) ? n9 - 9'd2 : 9'd0;
    lim_v   = ({1'b0, b2_r} < avail3) ? {1'b0, b2_r} : avail3;
    lim_g   = ({1'b0, b1_r} < avail2) ? {1'b0, b1_r} : avail2;
    vtot    = (lim_v + 9'd1) >> 1;
    rtot    = lim_g;
    ack_hit = (len_r == dfr_pkg::ACK_LENGTH) &&
              ((cmdb_r == cmd_vw_r) || (cmdb_r == cmd_rw_r)) &&
              (b0_r == dfr_pkg::ACK_CHAR_O) && (b1_r == dfr_pkg::ACK_CHAR_K);
    addr_nxt  = 16'd0;
    total_nxt = 6'd0;
    if (ovf_r) begin
      kind_nxt = dfr_pkg::KIND_OVERFLOW;
    end else if (ack_hit) begin
      kind_nxt = dfr_pkg::KIND_ACK;
    end else if (cmdb_r == cmd_vr_r) begin
      kind_nxt  = dfr_pkg::KIND_VAR;
      addr_nxt  = {b0_r, b1_r};
      total_nxt = (vtot > MAXE9) ? MAXE9[5:0] : vtot[5:0];
    end else if (cmdb_r == cmd_rr_r) begin
      kind_nxt  = dfr_pkg::KIND_REG;
      addr_nxt  = {8'd0, b0_r};
      total_nxt = (rtot > MAXE9) ? MAXE9[5:0] : rtot[5:0];
    end else begin
      kind_nxt = dfr_pkg::KIND_OTHER;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr1_r   <= dfr_pkg::HDR_FIRST_RST;
      hdr2_r   <= dfr_pkg::HDR_SECOND_RST;
      cmd_rw_r <= dfr_pkg::CMD_RW_RST;
      cmd_rr_r <= dfr_pkg::CMD_RR_RST;
      cmd_vw_r <= dfr_pkg::CMD_VW_RST;
      cmd_vr_r <= dfr_pkg::CMD_VR_RST;
    end else if (cfg_we) begin
      case (dfr_pkg::cfg_idx_t'(cfg_index))
        dfr_pkg::CFG_HDR_FIRST:  hdr1_r   <= cfg_wdata;
        dfr_pkg::CFG_HDR_SECOND: hdr2_r   <= cfg_wdata;
        dfr_pkg::CFG_CMD_RW:     cmd_rw_r <= cfg_wdata;
        dfr_pkg::CFG_CMD_RR:     cmd_rr_r <= cfg_wdata;
        dfr_pkg::CFG_CMD_VW:     cmd_vw_r <= cfg_wdata;
        dfr_pkg::CFG_CMD_VR:     cmd_vr_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r   <= 8'd0;
      cmdb_r  <= 8'd0;
      cnt_r   <= 8'd0;
      ovf_r   <= 1'b0;
      kind_r  <= dfr_pkg::KIND_OTHER;
      addr_r  <= 16'd0;
      total_r <= 6'd0;
      elem_r  <= 6'd0;
    end else begin
      if (cmd_i.cap_len) len_r <= in_tdata;
      if (cmd_i.cap_cmd) begin
        cmdb_r <= in_tdata;
        cnt_r  <= 8'd0;
        ovf_r  <= 1'b0;
      end
      if (cmd_i.pay_wr) begin
        cnt_r <= cnt_r + 8'd1;
        if (cnt9 >= DEPTH9) ovf_r <= 1'b1;
      end
      if (cmd_i.classify) begin
        kind_r  <= kind_nxt;
        addr_r  <= addr_nxt;
        total_r <= total_nxt;
        elem_r  <= 6'd0;
      end
      if (cmd_i.elem_inc) elem_r <= elem_r + 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.pay_wr && (cnt9 < DEPTH9)) mem[cnt_r[dfr_pkg::PAY_AW-1:0]] <= in_tdata;
    rd_data_r <= mem[rd_idx[dfr_pkg::PAY_AW-1:0]];
    rd_ok_r   <= {1'b0, rd_idx} < n9;
    if (cmd_i.cap_b0) b0_r <= byte_in;
    if (cmd_i.cap_b1) b1_r <= byte_in;
    if (cmd_i.cap_b2) b2_r <= byte_in;
    if (cmd_i.cap_hi) hi_r <= byte_in;
    if (cmd_i.cap_lo) lo_r <= byte_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd_i.emit != dfr_pkg::EM_NONE) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd_i.emit)
      dfr_pkg::EM_HDR: begin
        o_kind_r <= dfr_pkg::KIND_HDR_ERR;
        o_cmd_r  <= 8'd0;
        o_addr_r <= 16'd0;
        o_hv_r   <= 1'b0;
        o_val_r  <= 16'd0;
        o_idx_r  <= 6'd0;
        o_last_r <= 1'b1;
      end
      dfr_pkg::EM_HEAD: begin
        o_kind_r <= kind_r;
        o_cmd_r  <= cmdb_r;
        o_addr_r <= addr_r;
        o_hv_r   <= 1'b0;
        o_val_r  <= 16'd0;
        o_idx_r  <= 6'd0;
        o_last_r <= head_last;
      end
      dfr_pkg::EM_ELEM: begin
        o_kind_r <= kind_r;
        o_cmd_r  <= cmdb_r;
        o_addr_r <= addr_r;
        o_hv_r   <= 1'b1;
        o_val_r  <= (kind_r == dfr_pkg::KIND_VAR) ? {hi_r, lo_r} : {8'd0, hi_r};
        o_idx_r  <= elem_r;
        o_last_r <= elem_last;
      end
      default: ;
    endcase
  end

  always_comb begin
    sts_o.hdr1_ok   = (in_tdata == hdr1_r);
    sts_o.hdr2_ok   = (in_tdata == hdr2_r) || (in_tdata == 8'd0);
    sts_o.pay_done  = (cnt9 + 9'd1) >= need9;
    sts_o.slot_free = slot_free;
    sts_o.head_last = head_last;
    sts_o.elem_last = elem_last;
    sts_o.is_var    = (kind_r == dfr_pkg::KIND_VAR);
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, o_idx_r, o_val_r, o_hv_r, o_addr_r, o_cmd_r};
  assign out_tuser  = o_kind_r;
  assign out_tlast  = o_last_r;

  a_emit_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_i.emit != dfr_pkg::EM_NONE) |-> (!out_valid_r || out_tready))
    else $error("result loaded while output register is held");

  a_elem_range: assert property (@(posedge clk) disable iff (!rst_n)
    elem_r <= total_r)
    else $error("element counter past element total");

  a_ovf_count: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r |-> (cnt9 > DEPTH9))
    else $error("overflow flag without payload beyond depth");

endmodule

`default_nettype wire

// ===== rtl/core/dfr_ctrl.sv =====
// Controller: byte parse phases and the decode and result sequencer.
`default_nettype none

module dfr_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  input  wire dfr_pkg::ctrl_sts_t sts_i,
  output dfr_pkg::ctrl_cmd_t      cmd_o
);

  dfr_pkg::state_t state_r, state_nxt;
  logic            parse_st, acc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dfr_pkg::S_H1;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    parse_st  = (state_r == dfr_pkg::S_H1) || (state_r == dfr_pkg::S_H2) ||
                (state_r == dfr_pkg::S_LEN) || (state_r == dfr_pkg::S_CMD) ||
                (state_r == dfr_pkg::S_PAY);
    in_tready = parse_st && sts_i.slot_free;
    acc       = in_tvalid && in_tready;
    cmd_o     = '0;
    state_nxt = state_r;
    case (state_r)
      dfr_pkg::S_H1: begin
        if (acc) begin
          if (sts_i.hdr1_ok) state_nxt = dfr_pkg::S_H2;
          else cmd_o.emit = dfr_pkg::EM_HDR;
        end
      end
      dfr_pkg::S_H2: begin
        if (acc) begin
          if (sts_i.hdr2_ok) begin
            state_nxt = dfr_pkg::S_LEN;
          end else begin
            cmd_o.emit = dfr_pkg::EM_HDR;
            state_nxt  = dfr_pkg::S_H1;
          end
        end
      end
      dfr_pkg::S_LEN: begin
        if (acc) begin
          cmd_o.cap_len = 1'b1;
          state_nxt     = dfr_pkg::S_CMD;
        end
      end
      dfr_pkg::S_CMD: begin
        if (acc) begin
          cmd_o.cap_cmd = 1'b1;
          state_nxt     = dfr_pkg::S_PAY;
        end
      end
      dfr_pkg::S_PAY: begin
        if (acc) begin
          cmd_o.pay_wr = 1'b1;
          if (sts_i.pay_done) state_nxt = dfr_pkg::S_A0;
        end
      end
      dfr_pkg::S_A0: begin
        cmd_o.rsel = dfr_pkg::RS_B0;
        state_nxt  = dfr_pkg::S_A1;
      end
      dfr_pkg::S_A1: begin
        cmd_o.rsel   = dfr_pkg::RS_B1;
        cmd_o.cap_b0 = 1'b1;
        state_nxt    = dfr_pkg::S_A2;
      end
      dfr_pkg::S_A2: begin
        cmd_o.rsel   = dfr_pkg::RS_B2;
        cmd_o.cap_b1 = 1'b1;
        state_nxt    = dfr_pkg::S_A3;
      end
      dfr_pkg::S_A3: begin
        cmd_o.cap_b2 = 1'b1;
        state_nxt    = dfr_pkg::S_CLS;
      end
      dfr_pkg::S_CLS: begin
        cmd_o.classify = 1'b1;
        state_nxt      = dfr_pkg::S_HEAD;
      end
      dfr_pkg::S_HEAD: begin
        if (sts_i.slot_free) begin
          cmd_o.emit = dfr_pkg::EM_HEAD;
          state_nxt  = sts_i.head_last ? dfr_pkg::S_H1 : dfr_pkg::S_RH;
        end
      end
      dfr_pkg::S_RH: begin
        cmd_o.rsel = dfr_pkg::RS_HI;
        state_nxt  = dfr_pkg::S_RL;
      end
      dfr_pkg::S_RL: begin
        cmd_o.cap_hi = 1'b1;
        if (sts_i.is_var) begin
          cmd_o.rsel = dfr_pkg::RS_LO;
          state_nxt  = dfr_pkg::S_CL;
        end else begin
          state_nxt  = dfr_pkg::S_OUT;
        end
      end
      dfr_pkg::S_CL: begin
        cmd_o.cap_lo = 1'b1;
        state_nxt    = dfr_pkg::S_OUT;
      end
      dfr_pkg::S_OUT: begin
        if (sts_i.slot_free) begin
          cmd_o.emit = dfr_pkg::EM_ELEM;
          if (sts_i.elem_last) begin
            state_nxt = dfr_pkg::S_H1;
          end else begin
            cmd_o.elem_inc = 1'b1;
            state_nxt      = dfr_pkg::S_RH;
          end
        end
      end
      default: state_nxt = dfr_pkg::S_H1;
    endcase
  end

  a_pay_done: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && (state_r == dfr_pkg::S_PAY) && sts_i.pay_done) |=> (state_r == dfr_pkg::S_A0))
    else $error("completed frame did not start decode");

endmodule

`default_nettype wire

// ===== rtl/core/display_frame_receiver.sv =====
// Top level of the display frame receiver: controller plus datapath.
//
// Channel   Direction  Contents
// in_       slave      tdata[7:0] rx_byte
// out_      master     tdata: command_code, target_address, has_value, data_value,
//                      element_index; tuser: frame_kind; tlast: last_of_frame
// cfg_      write      cfg_index 0..5 selects header and command code registers
//
// One byte per cycle while inside a frame; a byte that ends a frame starts a
// decode of three registered reads of the payload memory and one classify step.
// The head result is then emitted; each register-read byte takes one read and
// each variable-read word two, through the single read port of the payload memory.
// A held output register stalls input and sequencer alike.
// Reset restores the register defaults and waits for the first header byte.
`default_nettype none

module display_frame_receiver (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] rx_byte
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [7:0] command_code, [23:8] target_address, [24] has_value,
  // [40:25] data_value, [46:41] element_index, [47] zero
  output logic [47:0]      out_tdata,
  output logic [2:0]       out_tuser,  // [2:0] frame_kind
  output logic             out_tlast,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [7:0]  cfg_wdata
);

  dfr_pkg::ctrl_cmd_t cmd;
  dfr_pkg::ctrl_sts_t sts;

  dfr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  dfr_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire

// ===== verif/tb_display_frame_receiver.sv =====
// Self-checking testbench for display_frame_receiver: random and directed byte streams.
module tb_display_frame_receiver;

  localparam int SEGMENT_BYTES  = 26;
  localparam int DRAIN_CYCLES   = 16;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef enum logic [2:0] {
    PH_SYNC1, PH_SYNC2, PH_LEN, PH_CMD, PH_PAYLOAD
  } parse_phase_t;

  typedef struct packed {
    dfr_pkg::kind_t kind;
    logic [7:0]     cmd;
    logic [15:0]    addr;
    logic           has_value;
    logic [15:0]    value;
    logic [5:0]     idx;
    logic           last;
  } frame_result_t;

  class frame_decode_board;
    logic [7:0]    hdr_first, hdr_second;
    logic [7:0]    cmd_reg_write, cmd_reg_read, cmd_var_write, cmd_var_read;
    parse_phase_t  phase;
    logic [7:0]    frame_len, frame_cmd;
    int unsigned   pay_count;
    bit            overflowed;
    logic [7:0]    pay_store [dfr_pkg::PAYLOAD_DEPTH];
    frame_result_t pending_results [$];
    int            errors;

    function new();
      hdr_first     = dfr_pkg::HDR_FIRST_RST;
      hdr_second    = dfr_pkg::HDR_SECOND_RST;
      cmd_reg_write = dfr_pkg::CMD_RW_RST;
      cmd_reg_read  = dfr_pkg::CMD_RR_RST;
      cmd_var_write = dfr_pkg::CMD_VW_RST;
      cmd_var_read  = dfr_pkg::CMD_VR_RST;
      phase         = PH_SYNC1;
      frame_len     = 8'h00;
      frame_cmd     = 8'h00;
      pay_count     = 0;
      overflowed    = 1'b0;
      errors        = 0;
    endfunction

    function void set_reg(dfr_pkg::cfg_idx_t idx, logic [7:0] v);
      case (idx)
        dfr_pkg::CFG_HDR_FIRST:  hdr_first = v;
        dfr_pkg::CFG_HDR_SECOND: hdr_second = v;
        dfr_pkg::CFG_CMD_RW:     cmd_reg_write = v;
        dfr_pkg::CFG_CMD_RR:     cmd_reg_read = v;
        dfr_pkg::CFG_CMD_VW:     cmd_var_write = v;
        dfr_pkg::CFG_CMD_VR:     cmd_var_read = v;
        default: ;
      endcase
    endfunction

    function logic [7:0] stored(int unsigned i);
      return (i < pay_count && i < dfr_pkg::PAYLOAD_DEPTH) ? pay_store[i] : 8'h00;
    endfunction

    function void add_result(dfr_pkg::kind_t kind, logic [7:0] cmd, logic [15:0] addr,
                             logic has_value, logic [15:0] value, logic [5:0] idx);
      frame_result_t r;
      r.kind      = kind;
      r.cmd       = cmd;
      r.addr      = addr;
      r.has_value = has_value;
      r.value     = value;
      r.idx       = idx;
      r.last      = 1'b0;
      pending_results.push_back(r);
    endfunction

    function void decode_frame();
      int unsigned held, avail, lim, i, e;
      logic [15:0] addr;
      held = pay_count < dfr_pkg::PAYLOAD_DEPTH ? pay_count : dfr_pkg::PAYLOAD_DEPTH;
      if (overflowed) begin
        add_result(dfr_pkg::KIND_OVERFLOW, frame_cmd, 16'h0, 1'b0, 16'h0, 6'd0);
      end else if (frame_len == dfr_pkg::ACK_LENGTH &&
                   (frame_cmd == cmd_var_write || frame_cmd == cmd_reg_write) &&
                   stored(0) == dfr_pkg::ACK_CHAR_O && stored(1) == dfr_pkg::ACK_CHAR_K) begin
        add_result(dfr_pkg::KIND_ACK, frame_cmd, 16'h0, 1'b0, 16'h0, 6'd0);
      end else if (frame_cmd == cmd_var_read) begin
        addr  = {stored(0), stored(1)};
        avail = held > 3 ? held - 3 : 0;
        lim   = stored(2) < avail ? stored(2) : avail;
        add_result(dfr_pkg::KIND_VAR, frame_cmd, addr, 1'b0, 16'h0, 6'd0);
        e = 0;
        for (i = 0; i < lim && e < dfr_pkg::MAX_ELEMENTS; i += 2) begin
          add_result(dfr_pkg::KIND_VAR, frame_cmd, addr, 1'b1,
                     {stored(3 + i), stored(4 + i)}, e[5:0]);
          e++;
        end
      end else if (frame_cmd == cmd_reg_read) begin
        addr  = {8'h00, stored(0)};
        avail = held > 2 ? held - 2 : 0;
        lim   = stored(1) < avail ? stored(1) : avail;
        add_result(dfr_pkg::KIND_REG, frame_cmd, addr, 1'b0, 16'h0, 6'd0);
        for (i = 0; i < lim && i < dfr_pkg::MAX_ELEMENTS; i++) begin
          add_result(dfr_pkg::KIND_REG, frame_cmd, addr, 1'b1, {8'h00, stored(2 + i)},
                     i[5:0]);
        end
      end else begin
        add_result(dfr_pkg::KIND_OTHER, frame_cmd, 16'h0, 1'b0, 16'h0, 6'd0);
      end
    endfunction

    function void note_rx_byte(logic [7:0] d);
      int unsigned   queued, need;
      frame_result_t r;
      queued = pending_results.size();
      case (phase)
        PH_SYNC2: begin
          if (d != hdr_second && d != 8'h00) begin
            phase     = PH_SYNC1;
            pay_count = 0;
            add_result(dfr_pkg::KIND_HDR_ERR, 8'h00, 16'h0, 1'b0, 16'h0, 6'd0);
          end else begin
            phase = PH_LEN;
          end
        end
        PH_LEN: begin
          frame_len = d;
          phase     = PH_CMD;
        end
        PH_CMD: begin
          frame_cmd  = d;
          pay_count  = 0;
          overflowed = 1'b0;
          phase      = PH_PAYLOAD;
        end
        PH_PAYLOAD: begin
          need = frame_len != 8'h00 ? frame_len - 1 : 0;
          if (pay_count < dfr_pkg::PAYLOAD_DEPTH) pay_store[pay_count] = d;
          else overflowed = 1'b1;
          pay_count++;
          if (pay_count >= need) begin
            decode_frame();
            phase      = PH_SYNC1;
            pay_count  = 0;
            overflowed = 1'b0;
          end
        end
        default: begin
          if (d != hdr_first) begin
            pay_count = 0;
            add_result(dfr_pkg::KIND_HDR_ERR, 8'h00, 16'h0, 1'b0, 16'h0, 6'd0);
          end else begin
            phase = PH_SYNC2;
          end
        end
      endcase
      if (pending_results.size() > queued) begin
        r = pending_results.pop_back();
        r.last = 1'b1;
        pending_results.push_back(r);
      end
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 40) $display("MISMATCH %0d: %s", errors, msg);
    endtask

    task check_frame_result(frame_result_t got);
      frame_result_t want;
      if (pending_results.size() == 0) begin
        report($sformatf("unexpected result kind %0d cmd %02h addr %04h",
                         got.kind, got.cmd, got.addr));
      end else begin
        want = pending_results.pop_front();
        if (got.kind != want.kind || got.cmd != want.cmd || got.addr != want.addr ||
            got.has_value != want.has_value || got.value != want.value ||
            got.idx != want.idx || got.last != want.last)
          report($sformatf({"got/exp kind %0d/%0d cmd %02h/%02h addr %04h/%04h ",
                            "val %0d:%04h/%0d:%04h idx %0d/%0d last %0d/%0d"},
                           got.kind, want.kind, got.cmd, want.cmd, got.addr, want.addr,
                           got.has_value, got.value, want.has_value, want.value,
                           got.idx, want.idx, got.last, want.last));
      end
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        out_tlast;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = dfr_pkg::CFG_HDR_FIRST;
  logic [7:0]  cfg_wdata = 8'h00;

  frame_decode_board board;
  int          send_idle_pct = 0;
  int          stall_pct = 0;
  bit          hold_request = 1'b0;
  int          hold_left = 0;
  int          quiet_cycles = 0;
  logic [7:0]  frame_bytes [$];
  logic [7:0]  body [$];

  logic [7:0] opening_bytes [27] = '{
    8'hFF,
    dfr_pkg::HDR_FIRST_RST, 8'h11,
    dfr_pkg::HDR_FIRST_RST, dfr_pkg::HDR_SECOND_RST, dfr_pkg::ACK_LENGTH,
    dfr_pkg::CMD_VW_RST, dfr_pkg::ACK_CHAR_O, dfr_pkg::ACK_CHAR_K,
    dfr_pkg::HDR_FIRST_RST, 8'h00, 8'h01, dfr_pkg::CMD_VR_RST, 8'hFF,
    dfr_pkg::HDR_FIRST_RST, 8'h00, 8'h00, 8'h00, 8'h00,
    dfr_pkg::HDR_FIRST_RST, dfr_pkg::HDR_SECOND_RST, 8'h05, dfr_pkg::CMD_RR_RST,
    8'h7F, 8'h03, 8'h00, 8'hFF
  };

  display_frame_receiver DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin : watch_ports
    frame_result_t got;
    if (rst_n) begin
      if (in_tvalid && in_tready) board.note_rx_byte(in_tdata);
      if (out_tvalid && out_tready) begin
        got.kind      = dfr_pkg::kind_t'(out_tuser);
        got.cmd       = out_tdata[7:0];
        got.addr      = out_tdata[23:8];
        got.has_value = out_tdata[24];
        got.value     = out_tdata[40:25];
        got.idx       = out_tdata[46:41];
        got.last      = out_tlast;
        board.check_frame_result(got);
      end
    end
  end

  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left = hold_left - 1;
    end else if (hold_request) begin
      hold_request = 1'b0;
      hold_left = HOLD_CYCLES;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  task send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task drain();
    while (board.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Bring the parser back to header search so settings change only between frames.
  task settle_parser();
    in_tvalid <= 1'b0;
    drain();
    while (board.phase != PH_SYNC1) begin
      send_byte(8'h00);
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    drain();
  endtask

  task apply_settings(input logic [7:0] hf, input logic [7:0] hs, input logic [7:0] rw,
                      input logic [7:0] rr, input logic [7:0] vw, input logic [7:0] vr);
    logic [7:0]        vals [6];
    dfr_pkg::cfg_idx_t idx;
    vals = '{hf, hs, rw, rr, vw, vr};
    idx  = dfr_pkg::CFG_HDR_FIRST;
    foreach (vals[i]) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx;
      cfg_wdata <= vals[i];
      board.set_reg(idx, vals[i]);
      @(posedge clk);
      idx = idx.next();
    end
    cfg_we <= 1'b0;
  endtask

  function void build_frame(bit force_overflow);
    int         pick, data_len, len_i, need;
    bit         shortable;
    logic [7:0] cmd;
    frame_bytes.delete();
    body.delete();
    shortable = 1'b0;
    pick = force_overflow ? 99 : $urandom_range(0, 99);
    if (pick < 8) begin
      repeat ($urandom_range(1, 4)) frame_bytes.push_back(8'($urandom_range(0, 255)));
    end else if (pick < 13) begin
      frame_bytes.push_back(board.hdr_first);
      frame_bytes.push_back(8'($urandom_range(0, 255)));
    end else begin
      pick = force_overflow ? 0 : $urandom_range(0, 99);
      if (pick < 4) begin
        case ($urandom_range(0, 4))
          0: len_i = 64;
          1: len_i = 65;
          2: len_i = 66;
          3: len_i = 70;
          default: len_i = 255;
        endcase
        if (force_overflow) len_i = 66;
        case ($urandom_range(0, 2))
          0: cmd = board.cmd_var_read;
          1: cmd = board.cmd_reg_read;
          default: cmd = 8'($urandom_range(0, 255));
        endcase
        repeat (len_i - 1) body.push_back(8'($urandom_range(0, 255)));
      end else if (pick < 22) begin
        cmd = $urandom_range(0, 1) ? board.cmd_var_write : board.cmd_reg_write;
        body.push_back(dfr_pkg::ACK_CHAR_O);
        body.push_back(dfr_pkg::ACK_CHAR_K);
        if ($urandom_range(0, 3) == 0) body[$urandom_range(0, 1)] = 8'($urandom_range(0, 255));
        len_i = dfr_pkg::ACK_LENGTH;
        shortable = 1'b1;
      end else if (pick < 75) begin
        data_len = $urandom_range(0, 3) == 0 ? $urandom_range(0, 40) : $urandom_range(0, 8);
        cmd = pick < 50 ? board.cmd_var_read : board.cmd_reg_read;
        if (pick < 50) body.push_back(8'($urandom_range(0, 255)));
        body.push_back(8'($urandom_range(0, 255)));
        case ($urandom_range(0, 3))
          0: body.push_back(8'(data_len));
          1: body.push_back(8'(data_len + 1));
          2: body.push_back(8'($urandom_range(0, 255)));
          default: body.push_back(8'($urandom_range(0, data_len)));
        endcase
        repeat (data_len) body.push_back(8'($urandom_range(0, 255)));
        len_i = body.size() + 1;
        shortable = 1'b1;
      end else if (pick < 90) begin
        cmd   = 8'($urandom_range(0, 255));
        len_i = $urandom_range(0, 12);
      end else begin
        len_i = $urandom_range(0, 2);
        case ($urandom_range(0, 4))
          0: cmd = board.cmd_reg_write;
          1: cmd = board.cmd_reg_read;
          2: cmd = board.cmd_var_write;
          3: cmd = board.cmd_var_read;
          default: cmd = 8'($urandom_range(0, 255));
        endcase
      end
      if (shortable && $urandom_range(0, 7) == 0) len_i = $urandom_range(0, 4);
      need = len_i > 1 ? len_i - 1 : 1;
      frame_bytes.push_back(board.hdr_first);
      frame_bytes.push_back($urandom_range(0, 1) ? board.hdr_second : 8'h00);
      frame_bytes.push_back(8'(len_i));
      frame_bytes.push_back(cmd);
      for (int i = 0; i < need; i++)
        frame_bytes.push_back(i < body.size() ? body[i] : 8'($urandom_range(0, 255)));
      if ($urandom_range(0, 24) == 0)
        repeat ($urandom_range(1, need)) void'(frame_bytes.pop_back());
    end
  endfunction

  initial begin
    int sent;
    bit first_frame;
    board = new();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (opening_bytes[i]) send_byte(opening_bytes[i]);
    settle_parser();

    for (int seg = 0; seg < 6; seg++) begin
      case (seg)
        0: begin
          send_idle_pct = 0;
          stall_pct     = 0;
        end
        1: begin
          apply_settings(8'hFF, 8'h00, 8'h00, 8'hFF, 8'h7F, 8'h80);
          send_idle_pct = 79;
          stall_pct     = 0;
        end
        2: begin
          apply_settings(8'h00, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'hFF);
          send_idle_pct = 0;
          stall_pct     = 79;
        end
        3: begin
          apply_settings(8'h3C, 8'hC3, 8'h42, 8'h42, 8'h42, 8'h42);
          send_idle_pct = 17;
          stall_pct     = 17;
        end
        4: begin
          apply_settings(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                         8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                         8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
          send_idle_pct = 0;
          stall_pct     = 79;
        end
        default: begin
          apply_settings(dfr_pkg::HDR_FIRST_RST, dfr_pkg::HDR_SECOND_RST,
                         dfr_pkg::CMD_RW_RST, dfr_pkg::CMD_RR_RST,
                         dfr_pkg::CMD_VW_RST, dfr_pkg::CMD_VR_RST);
          send_idle_pct = 0;
          stall_pct     = 0;
          hold_request  = 1'b1;
        end
      endcase
      sent = 0;
      first_frame = 1'b1;
      while (sent < SEGMENT_BYTES) begin
        build_frame(seg == 0 && first_frame);
        first_frame = 1'b0;
        foreach (frame_bytes[i]) send_byte(frame_bytes[i]);
        sent += frame_bytes.size();
      end
      settle_parser();
    end

    if (board.pending_results.size() != 0)
      board.report($sformatf("%0d results never arrived", board.pending_results.size()));
    if (board.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
